/* design/assert_macros.svh */
// Assertion macros shared by the rank successor search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define RSPS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define RSPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RSPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rsps_pkg.sv */
// Shared types and constants of the rank successor position search.
`timescale 1ns / 1ps
`default_nettype none

package rsps_pkg;

	localparam int RANK_W          = 9;
	localparam int POS_W           = 9;
	localparam int DEF_MAX_ENTRIES = 512;
	localparam int QUEUE_DEPTH     = 4;
	localparam int IN_TDATA_W      = 16;
	localparam int IN_TUSER_W      = 2;
	localparam int OUT_W           = POS_W + 2;
	localparam int OUT_TDATA_W     = 16;
	localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_W;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_SUCC   = 2'd1,
		CMD_MIN    = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// decoded command word carried through the queue
	typedef struct packed {
		cmd_t              cmd;
		logic              is_query;
		logic [RANK_W-1:0] rank;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// result word, position in the low bits
	typedef struct packed {
		logic             empty_res;
		logic             wrapped;
		logic [POS_W-1:0] position;
	} result_t;

endpackage

`default_nettype wire

/* design/rsps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rsps_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/rsps_front.sv */
// Front end: takes input words, decodes the command and feeds the queue.
`timescale 1ns / 1ps
`default_nettype none

module rsps_front import rsps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic [IN_TUSER_W-1:0] s_tuser,
	input  wire fifo_stat_t            q_stat,
	output logic                       q_push,
	output op_t                        q_op
);

	logic valid_s1;
	op_t  op_s1;
	cmd_t cmd;

	assign cmd      = cmd_t'(s_tuser);
	assign q_push   = valid_s1 && !q_stat.full;
	assign s_tready = !valid_s1 || !q_stat.full;
	assign q_op     = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1.cmd      <= cmd;
			op_s1.is_query <= (cmd == CMD_SUCC) || (cmd == CMD_MIN);
			op_s1.rank     <= s_tdata[RANK_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/rsps_fifo.sv */
// Short command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsps_fifo import rsps_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	input  wire logic pop,
	output op_t       head_op,
	output fifo_stat_t stat
);

	op_t           slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign stat.full  = (fill_q == CW'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign head_op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	`RSPS_ASSERT_IMP(a_no_overflow, push, !stat.full, "push into full queue")
	`RSPS_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "pop from empty queue")
	`RSPS_ASSERT_NXT(a_fill_grows, push && !pop && !stat.full, !stat.empty,
		"queue empty after push")

endmodule

`default_nettype wire

/* design/rsps_back.sv */
// Back end: holds the rank store, runs appends, clears and query scans.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsps_back import rsps_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1),
	localparam int EXT_W = AW + POS_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire op_t                    head_op,
	input  wire fifo_stat_t             q_stat,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [POS_W-1:0]  last_pos_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [RANK_W-1:0] key_q;
	logic              use_key_q;
	logic              issuing_q;
	logic [AW-1:0]     rd_idx_q;
	logic              rd_valid_s1;
	logic              rd_last_s1;
	logic [AW-1:0]     rd_idx_s1;

	logic [RANK_W-1:0] best_all_q;
	logic [AW-1:0]     pos_all_q;
	logic [RANK_W-1:0] best_key_q;
	logic [AW-1:0]     pos_key_q;
	logic              found_key_q;

	logic              wr_en;
	logic              rd_en;
	logic [RANK_W-1:0] rd_data;
	logic              store_full;
	logic              rd_is_last;
	logic              first;
	logic              gt_key;
	logic              res_load;
	logic [AW-1:0]     sel_pos;
	logic [EXT_W-1:0]  sel_pos_ext;
	logic [POS_W-1:0]  sel_pos_out;

	assign store_full = (count_q >= CW'(MAX_ENTRIES));
	assign q_pop      = (state_q == ST_IDLE) && !q_stat.empty &&
	                    (!head_op.is_query || !out_valid_q);
	assign wr_en      = q_pop && (head_op.cmd == CMD_APPEND) && !store_full;
	assign rd_en      = (state_q == ST_SCAN) && issuing_q;
	assign rd_is_last = (CW'(rd_idx_q) == count_q - 1'b1);

	// a result word loads at scan end or for a query on an empty store
	assign res_load   = (state_q == ST_FINISH) ||
	                    (q_pop && head_op.is_query && (count_q == '0));

	assign first  = (rd_idx_s1 == '0);
	assign gt_key = (rd_data > key_q);

	assign sel_pos     = (use_key_q && found_key_q) ? pos_key_q : pos_all_q;
	assign sel_pos_ext = EXT_W'(sel_pos);
	assign sel_pos_out = sel_pos_ext[POS_W-1:0];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_q};

	rsps_ram #(
		.WIDTH (RANK_W),
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (head_op.rank),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			last_pos_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			key_q       <= '0;
			use_key_q   <= 1'b0;
			issuing_q   <= 1'b0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			best_all_q  <= '0;
			pos_all_q   <= '0;
			best_key_q  <= '0;
			pos_key_q   <= '0;
			found_key_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (head_op.cmd)
							CMD_APPEND: begin
								if (!store_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_SUCC, CMD_MIN: begin
								if (count_q == '0) begin
									out_q.position  <= last_pos_q;
									out_q.wrapped   <= 1'b0;
									out_q.empty_res <= 1'b1;
								end else begin
									key_q     <= head_op.rank;
									use_key_q <= (head_op.cmd == CMD_SUCC);
									rd_idx_q  <= '0;
									issuing_q <= 1'b1;
									state_q   <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						rd_idx_q   <= rd_idx_q + 1'b1;
						rd_idx_s1  <= rd_idx_q;
						rd_last_s1 <= rd_is_last;
						if (rd_is_last) begin
							issuing_q <= 1'b0;
						end
					end
					if (rd_valid_s1) begin
						// strict compares keep the lowest position on ties
						if (first || rd_data < best_all_q) begin
							best_all_q <= rd_data;
							pos_all_q  <= rd_idx_s1;
						end
						if (gt_key && (first || !found_key_q || rd_data < best_key_q)) begin
							best_key_q  <= rd_data;
							pos_key_q   <= rd_idx_s1;
							found_key_q <= 1'b1;
						end else if (first) begin
							found_key_q <= 1'b0;
						end
						if (rd_last_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					out_q.position  <= sel_pos_out;
					out_q.wrapped   <= use_key_q && !found_key_q;
					out_q.empty_res <= 1'b0;
					last_pos_q      <= sel_pos_out;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RSPS_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES), "entry count above capacity")
	`RSPS_ASSERT_NXT(a_finish_out, state_q == ST_FINISH, out_valid_q,
		"scan finished without a result")
	`RSPS_ASSERT_IMP(a_query_slot, q_pop && head_op.is_query, !out_valid_q,
		"query started while result pending")

endmodule

`default_nettype wire

/* design/rank_successor_position_search.sv */
// Top level of the rank successor position search.
//
//  channel  | dir | tdata                                | tuser
//  ---------+-----+--------------------------------------+------------
//  s_axis   | in  | [8:0] rank                           | [1:0] cmd
//  m_axis   | out | [8:0] position, [9] wrapped,         | -
//           |     | [10] empty_res                       |
//
// Timing: append and clear finish in the back end as they leave the queue; a
//   query scans the store one entry per cycle through the single read port
//   of the rank store. A query on an empty store loads its result without a
//   scan.
// Reset: control state only; the rank store holds no reset value and needs
//   no clearing pass, reads stay below the entry count.
// Stalls: a front register and a four-word queue keep taking words until it
//   fills while the back end scans or a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module rank_successor_position_search import rsps_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input words: tdata = rank [8:0]; tuser = cmd [1:0]
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	// result words: tdata = position [8:0], wrapped [9], empty_res [10]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	fifo_stat_t q_stat;
	logic       q_push;
	logic       q_pop;
	op_t        q_in_op;
	op_t        q_head_op;

	// decode and register each input word
	rsps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_op     (q_in_op)
	);

	// decouples the front from the scanning back end
	rsps_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_in_op),
		.pop     (q_pop),
		.head_op (q_head_op),
		.stat    (q_stat)
	);

	// rank store, entry count, scan and result register
	rsps_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_op  (q_head_op),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
